FILE: rtl/bcs_pkg.sv
// bcs_pkg: types, widths and fixed-point constants of the brightness/contrast/saturation
// pipeline; used by every rtl file but bcs_stream_if, depends on nothing

package bcs_pkg;

  localparam int NUM_STAGES = 7;

  // datapath widths
  localparam int CHAN_W = 8;
  localparam int BRI_W  = 9;
  localparam int FAC_W  = 16;
  localparam int D_W    = 11;
  localparam int PC_W   = 28;
  localparam int Y_W    = 20;
  localparam int LW_W   = 17;
  localparam int LP_W   = 37;
  localparam int LS_W   = 38;
  localparam int DF_W   = 21;
  localparam int PS_W   = 38;
  localparam int Z_W    = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int CONTRAST_SHIFT = 6;
  localparam int LUMA_SHIFT     = 16;
  localparam int SAT_SHIFT      = 14;

  localparam logic signed [D_W-1:0]   MID_LEVEL    = 11'sd128;
  localparam logic signed [Y_W-1:0]   MID_LEVEL_Q8 = 20'sd32768;
  localparam logic signed [Z_W-1:0]   OUT_MAX_Q8   = 24'sd65280;
  localparam logic [CHAN_W-1:0]       CHAN_MAX     = 8'hFF;
  localparam logic [CHAN_W-1:0]       CHAN_MIN     = 8'h00;

  localparam logic signed [BRI_W-1:0] BRI_MIN = -9'sd255;
  localparam logic signed [7:0]       PCT_MIN = -8'sd100;
  localparam logic signed [7:0]       PCT_MAX = 8'sd100;

  localparam logic [FAC_W-1:0] FACTOR_UNITY = 16'd16384;

  // rec.601 weights in q0.16
  localparam logic [LW_W-1:0] LUMA_W [3] = '{17'd19595, 17'd38470, 17'd7471};

  // ceil(2^25 / 25), exact quotient for dividends below 2^20
  localparam logic [20:0] RECIP_25 = 21'd1342178;
  localparam int          RECIP_SHIFT = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_CONTRAST   = 2'd1,
    REG_SATURATION = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic signed [BRI_W-1:0] brightness;
    logic [FAC_W-1:0]        contrast_factor;
    logic [FAC_W-1:0]        saturation_factor;
  } cfg_t;

  // (pct + 100) / 100 in q2.14, rounded half up
  // equals floor((n * 4096 + 12) / 25) with n = pct + 100
  function automatic logic [FAC_W-1:0] factor_q14(input logic signed [7:0] pct);
    logic signed [8:0] n;
    logic [19:0]       w;
    logic [40:0]       prod;
    n    = 9'(pct) + 9'sd100;
    w    = {4'd0, n[7:0], 8'd0} * 20'd16 + 20'd12;
    prod = {21'd0, w} * {20'd0, RECIP_25};
    return prod[RECIP_SHIFT +: FAC_W];
  endfunction

endpackage

FILE: rtl/bcs_stream_if.sv
// bcs_stream_if: valid/ready stream channel carrying one pixel per request
// payload type comes from bcs_pkg at the point of use

interface bcs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rgb_brightness_contrast_saturation.sv
// rgb_brightness_contrast_saturation: top level, pipeline control and stage wiring
// depends on bcs_pkg, bcs_stream_if, bcs_cfg, bcs_contrast, bcs_luma, bcs_sat

// Adjusts one 8-bit RGB pixel per request: brightness offset, contrast about mid gray,
// then saturation about rec.601 luminance, clamped to 0..255. The datapath is a
// seven-stage pipeline (offset, contrast multiply, contrast shift, luma multiplies,
// luma sum, saturation multiply, clamp into the output register); a new pixel is taken
// every cycle while the output does not stall. Each stage holds while the one after it
// is full and stalled; a stage with no valid pixel always loads, so bubbles are squeezed
// out. Registers are written through the plain write port; writes outside a register's
// range saturate to its nearest bound, and contrast and saturation factors are computed
// at write time.

module rgb_brightness_contrast_saturation (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bcs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  bcs_stream_if.sink                         pix_i,
  bcs_stream_if.source                       pix_o
);

  localparam int NS = bcs_pkg::NUM_STAGES;

  bcs_pkg::cfg_t                     cfg;
  logic [NS-1:0]                     en;
  logic [NS-1:0]                     valid_d, valid_q;
  logic signed [bcs_pkg::Y_W-1:0]    y_c [3];
  logic signed [bcs_pkg::Y_W-1:0]    y_l [3];
  logic signed [bcs_pkg::Y_W-1:0]    lum;

  // a stage loads when empty or when its contents move on
  always_comb begin
    en[NS-1] = !valid_q[NS-1] || pix_o.ready;
    for (int k = NS-2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = pix_i.valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign pix_i.ready = en[0];
  assign pix_o.valid = valid_q[NS-1];

  bcs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bcs_contrast u_contrast (
    .clk_i        (clk_i),
    .en_i         (en[2:0]),
    .pix_i        (pix_i.data),
    .brightness_i (cfg.brightness),
    .factor_i     (cfg.contrast_factor),
    .y_o          (y_c)
  );

  bcs_luma u_luma (
    .clk_i (clk_i),
    .en_i  (en[4:3]),
    .y_i   (y_c),
    .y_o   (y_l),
    .lum_o (lum)
  );

  bcs_sat u_sat (
    .clk_i    (clk_i),
    .en_i     (en[6:5]),
    .y_i      (y_l),
    .lum_i    (lum),
    .factor_i (cfg.saturation_factor),
    .pix_o    (pix_o.data)
  );

endmodule

FILE: rtl/bcs_cfg.sv
// bcs_cfg: configuration registers with range saturation and factor precompute
// depends on bcs_pkg

module bcs_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bcs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output bcs_pkg::cfg_t                      cfg_o
);

  bcs_pkg::cfg_t           cfg_d, cfg_q;
  logic signed [8:0]       bri;
  logic signed [7:0]       pct, pct_sat;

  always_comb begin
    bri = $signed(cfg_data_i);
    pct = $signed(cfg_data_i[7:0]);
    if (pct < bcs_pkg::PCT_MIN) begin
      pct_sat = bcs_pkg::PCT_MIN;
    end else if (pct > bcs_pkg::PCT_MAX) begin
      pct_sat = bcs_pkg::PCT_MAX;
    end else begin
      pct_sat = pct;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bcs_pkg::REG_BRIGHTNESS: begin
          cfg_d.brightness = (bri < bcs_pkg::BRI_MIN) ? bcs_pkg::BRI_MIN : bri;
        end
        bcs_pkg::REG_CONTRAST: begin
          cfg_d.contrast_factor = bcs_pkg::factor_q14(pct_sat);
        end
        bcs_pkg::REG_SATURATION: begin
          cfg_d.saturation_factor = bcs_pkg::factor_q14(pct_sat);
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness        <= '0;
      cfg_q.contrast_factor   <= bcs_pkg::FACTOR_UNITY;
      cfg_q.saturation_factor <= bcs_pkg::FACTOR_UNITY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/bcs_contrast.sv
// bcs_contrast: brightness offset and contrast scaling about mid level, three stages
// depends on bcs_pkg

module bcs_contrast (
  input  logic                              clk_i,
  input  logic [2:0]                        en_i,
  input  bcs_pkg::pix_in_t                  pix_i,
  input  logic signed [bcs_pkg::BRI_W-1:0]  brightness_i,
  input  logic [bcs_pkg::FAC_W-1:0]         factor_i,
  output logic signed [bcs_pkg::Y_W-1:0]    y_o [3]
);

  logic [bcs_pkg::CHAN_W-1:0]        chan [3];
  logic signed [bcs_pkg::D_W-1:0]    d_d [3], d_q [3];
  logic signed [bcs_pkg::PC_W-1:0]   pc_d [3], pc_q [3];
  logic signed [bcs_pkg::Y_W-1:0]    y_d [3], y_q [3];

  assign chan[0] = pix_i.red_in;
  assign chan[1] = pix_i.green_in;
  assign chan[2] = pix_i.blue_in;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d_d[c]  = bcs_pkg::D_W'($signed({1'b0, chan[c]}))
              + bcs_pkg::D_W'(brightness_i) - bcs_pkg::MID_LEVEL;
      pc_d[c] = bcs_pkg::PC_W'(d_q[c]) * bcs_pkg::PC_W'($signed({1'b0, factor_i}));
      y_d[c]  = bcs_pkg::Y_W'(pc_q[c] >>> bcs_pkg::CONTRAST_SHIFT) + bcs_pkg::MID_LEVEL_Q8;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (en_i[0]) begin
        d_q[c] <= d_d[c];
      end
      if (en_i[1]) begin
        pc_q[c] <= pc_d[c];
      end
      if (en_i[2]) begin
        y_q[c] <= y_d[c];
      end
    end
  end

  assign y_o = y_q;

endmodule

FILE: rtl/bcs_luma.sv
// bcs_luma: rec.601 luminance of the contrast-adjusted pixel, two stages
// depends on bcs_pkg

module bcs_luma (
  input  logic                            clk_i,
  input  logic [1:0]                      en_i,
  input  logic signed [bcs_pkg::Y_W-1:0]  y_i [3],
  output logic signed [bcs_pkg::Y_W-1:0]  y_o [3],
  output logic signed [bcs_pkg::Y_W-1:0]  lum_o
);

  logic signed [bcs_pkg::LP_W-1:0] lp_d [3], lp_q [3];
  logic signed [bcs_pkg::Y_W-1:0]  y3_q [3], y4_q [3];
  logic signed [bcs_pkg::LS_W-1:0] sum;
  logic signed [bcs_pkg::Y_W-1:0]  lum_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lp_d[c] = bcs_pkg::LP_W'(y_i[c])
              * bcs_pkg::LP_W'($signed({1'b0, bcs_pkg::LUMA_W[c]}));
    end
    sum = bcs_pkg::LS_W'(lp_q[0]) + bcs_pkg::LS_W'(lp_q[1]) + bcs_pkg::LS_W'(lp_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      lp_q <= lp_d;
      y3_q <= y_i;
    end
    if (en_i[1]) begin
      lum_q <= $signed(sum[bcs_pkg::LUMA_SHIFT +: bcs_pkg::Y_W]);
      y4_q  <= y3_q;
    end
  end

  assign y_o   = y4_q;
  assign lum_o = lum_q;

endmodule

FILE: rtl/bcs_sat.sv
// bcs_sat: saturation scaling about luminance, clamp and output register, two stages
// depends on bcs_pkg

module bcs_sat (
  input  logic                            clk_i,
  input  logic [1:0]                      en_i,
  input  logic signed [bcs_pkg::Y_W-1:0]  y_i [3],
  input  logic signed [bcs_pkg::Y_W-1:0]  lum_i,
  input  logic [bcs_pkg::FAC_W-1:0]       factor_i,
  output bcs_pkg::pix_out_t               pix_o
);

  logic signed [bcs_pkg::DF_W-1:0]  df [3];
  logic signed [bcs_pkg::PS_W-1:0]  ps_d [3], ps_q [3];
  logic signed [bcs_pkg::Y_W-1:0]   lum_q;
  logic signed [bcs_pkg::Z_W-1:0]   z [3];
  logic [bcs_pkg::CHAN_W-1:0]       out_d [3], out_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      df[c]   = bcs_pkg::DF_W'(y_i[c]) - bcs_pkg::DF_W'(lum_i);
      ps_d[c] = bcs_pkg::PS_W'(df[c]) * bcs_pkg::PS_W'($signed({1'b0, factor_i}));
      z[c]    = bcs_pkg::Z_W'(lum_q) + bcs_pkg::Z_W'(ps_q[c] >>> bcs_pkg::SAT_SHIFT);
      if (z[c] < 0) begin
        out_d[c] = bcs_pkg::CHAN_MIN;
      end else if (z[c] >= bcs_pkg::OUT_MAX_Q8) begin
        out_d[c] = bcs_pkg::CHAN_MAX;
      end else begin
        out_d[c] = z[c][15:8];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ps_q  <= ps_d;
      lum_q <= lum_i;
    end
    if (en_i[1]) begin
      out_q <= out_d;
    end
  end

  assign pix_o.red_out   = out_q[0];
  assign pix_o.green_out = out_q[1];
  assign pix_o.blue_out  = out_q[2];

endmodule

FILE: rtl/bcs_checker.sv
// bcs_checker: port-level checks of the pixel pipeline, bound to the top level
// depends on bcs_pkg and rgb_brightness_contrast_saturation

module bcs_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  bcs_pkg::pix_out_t  out_data_i
);

  logic in_req;
  assign in_req = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("output pixel changed while stalled");

  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled although output drains");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("accepted pixel did not reach the output in seven cycles");

endmodule

bind rgb_brightness_contrast_saturation bcs_checker u_bcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .out_data_i  (pix_o.data)
);

FILE: test/rgb_brightness_contrast_saturation_test.sv
// rgb_brightness_contrast_saturation_test: drives random and corner pixels through the
// brightness/contrast/saturation block under several register settings and checks each result
// against a fixed-point predictor; depends on bcs_pkg, bcs_stream_if and the rtl top level
`timescale 1ns / 100ps

module rgb_brightness_contrast_saturation_test;
  import bcs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int LATENCY = NUM_STAGES;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENTS = 15;
  localparam int SEGMENT_LEN = 100;

  class bcs_scoreboard;
    int brightness;
    int contrast;
    int saturation;
    int errors;
    pix_out_t expected_pixels[$];

    function new();
      brightness = 0;
      contrast   = 0;
      saturation = 0;
      errors     = 0;
    endfunction

    task report(string msg);
      $display("[%0t] %s", $time, msg);
      errors++;
    endtask

    function int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BRIGHTNESS: brightness = clamp_int(int'($signed(data)), -255, 255);
        REG_CONTRAST:   contrast   = clamp_int(int'($signed(data[7:0])), -100, 100);
        REG_SATURATION: saturation = clamp_int(int'($signed(data[7:0])), -100, 100);
        default: ;
      endcase
    endfunction

    function longint factor_q14(int pct);
      return ((longint'(pct) + 100) * 16384 + 50) / 100;
    endfunction

    function logic [CHAN_W-1:0] clamp_chan(longint z);
      if (z < 0) return 8'd0;
      if (z >= 65280) return 8'd255;
      return 8'(z >>> 8);
    endfunction

    function pix_out_t adjust_pixel(pix_in_t p);
      longint fc;
      longint fs;
      longint x;
      longint lum;
      longint y[3];
      longint chan[3];
      pix_out_t r;
      fc = factor_q14(contrast);
      fs = factor_q14(saturation);
      chan[0] = p.red_in;
      chan[1] = p.green_in;
      chan[2] = p.blue_in;
      for (int i = 0; i < 3; i++) begin
        x = chan[i] + brightness;
        y[i] = (((x - 128) * fc) >>> 6) + 32768;
      end
      lum = (19595 * y[0] + 38470 * y[1] + 7471 * y[2]) >>> 16;
      r.red_out   = clamp_chan(lum + (((y[0] - lum) * fs) >>> 14));
      r.green_out = clamp_chan(lum + (((y[1] - lum) * fs) >>> 14));
      r.blue_out  = clamp_chan(lum + (((y[2] - lum) * fs) >>> 14));
      return r;
    endfunction

    function void note_request(pix_in_t p);
      expected_pixels.push_back(adjust_pixel(p));
    endfunction

    task check_result(pix_out_t got);
      pix_out_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected pixel %h", got));
      end else begin
        want = expected_pixels.pop_front();
        if (got.red_out != want.red_out)
          report($sformatf("red_out %0d, want %0d", got.red_out, want.red_out));
        if (got.green_out != want.green_out)
          report($sformatf("green_out %0d, want %0d", got.green_out, want.green_out));
        if (got.blue_out != want.blue_out)
          report($sformatf("blue_out %0d, want %0d", got.blue_out, want.blue_out));
      end
    endtask

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bcs_stream_if #(.T(pix_in_t))  pix_in ();
  bcs_stream_if #(.T(pix_out_t)) pix_out ();

  bcs_scoreboard sb;
  int src_idle_pct;
  int sink_stall_pct;
  int cycle_count;

  rgb_brightness_contrast_saturation u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_in),
    .pix_o      (pix_out)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_in.valid && pix_in.ready) sb.note_request(pix_in.data);
      if (pix_out.valid && pix_out.ready) sb.check_result(pix_out.data);
    end
  end

  always @(posedge clk_i) begin
    pix_out.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_pixel(pix_in_t p);
    if ($urandom_range(99) < src_idle_pct) begin
      pix_in.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    pix_in.valid <= 1'b1;
    pix_in.data  <= p;
    do @(posedge clk_i); while (!pix_in.ready);
  endtask

  // waits on a clock edge before polling so the last accepted request is already noted
  task automatic wait_drained();
    pix_in.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] spare, logic [CFG_DATA_W-1:0] bri,
                              logic [CFG_DATA_W-1:0] con, logic [CFG_DATA_W-1:0] sat);
    logic [CFG_IDX_W-1:0] order[4];
    logic [CFG_DATA_W-1:0] vals[4];
    order = '{REG_SPARE, REG_BRIGHTNESS, REG_CONTRAST, REG_SATURATION};
    vals  = '{spare, bri, con, sat};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= order[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(order[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic pix_in_t pixel(int r, int g, int b);
    pix_in_t p;
    p.red_in   = 8'(r);
    p.green_in = 8'(g);
    p.blue_in  = 8'(b);
    return p;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pct_word(int v);
    return {1'($urandom_range(1)), 8'(v)};
  endfunction

  task automatic random_config();
    logic [CFG_DATA_W-1:0] spare;
    logic [CFG_DATA_W-1:0] bri;
    logic [CFG_DATA_W-1:0] con;
    logic [CFG_DATA_W-1:0] sat;
    spare = 9'($urandom_range(511));
    case ($urandom_range(3))
      0: begin
        bri = 9'($urandom_range(511));
        con = 9'($urandom_range(511));
        sat = 9'($urandom_range(511));
      end
      1: begin
        bri = 9'(int'($urandom_range(510)) - 255);
        con = pct_word(int'($urandom_range(200)) - 100);
        sat = pct_word(int'($urandom_range(200)) - 100);
      end
      2: begin
        bri = 9'((int'($urandom_range(2)) - 1) * 255);
        con = pct_word((int'($urandom_range(2)) - 1) * 100);
        sat = pct_word((int'($urandom_range(2)) - 1) * 100);
      end
      default: begin
        bri = 9'(int'($urandom_range(40)) - 20);
        con = pct_word(int'($urandom_range(40)) - 20);
        sat = pct_word(int'($urandom_range(40)) - 20);
      end
    endcase
    program_regs(spare, bri, con, sat);
  endtask

  initial begin
    pix_in_t p;
    sb = new();
    cycle_count = 0;
    src_idle_pct = 19;
    sink_stall_pct = 58;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_BRIGHTNESS;
    cfg_data_i = '0;
    pix_in.valid = 1'b0;
    pix_in.data = '0;
    pix_out.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    send_pixel(pixel(0, 0, 0));
    send_pixel(pixel(255, 255, 255));
    send_pixel(pixel(255, 0, 0));
    send_pixel(pixel(0, 255, 0));
    send_pixel(pixel(0, 0, 255));
    send_pixel(pixel(128, 128, 128));
    send_pixel(pixel(8'h55, 8'hAA, 8'h0F));
    wait_drained();

    // upper bounds everywhere
    program_regs(9'h1FF, 9'd255, 9'd100, 9'd100);
    send_pixel(pixel(0, 0, 0));
    send_pixel(pixel(255, 128, 0));
    send_pixel(pixel(10, 200, 90));
    wait_drained();

    // writes past the range saturate, bit 8 ignored on percents
    program_regs(9'h000, 9'h100, 9'h180, 9'h07F);
    send_pixel(pixel(255, 255, 255));
    send_pixel(pixel(0, 128, 255));
    send_pixel(pixel(200, 30, 120));
    wait_drained();

    // grayscale
    program_regs(9'h0AA, 9'd0, 9'd100, 9'h180);
    send_pixel(pixel(255, 0, 0));
    send_pixel(pixel(0, 255, 255));
    send_pixel(pixel(37, 150, 240));
    wait_drained();

    // flat contrast
    program_regs(9'h155, 9'h1F0, 9'h09C, 9'h000);
    send_pixel(pixel(255, 255, 255));
    send_pixel(pixel(0, 90, 180));
    wait_drained();

    for (int s = 0; s < SEGMENTS; s++) begin
      if (s < SEGMENTS / 3) begin
        src_idle_pct = 19;
        sink_stall_pct = 58;
      end else if (s < 2 * SEGMENTS / 3) begin
        src_idle_pct = 58;
        sink_stall_pct = 19;
      end else begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      random_config();
      for (int i = 0; i < SEGMENT_LEN; i++) begin
        if (i == SEGMENT_LEN / 2) wait_drained();
        p.red_in   = rand_chan();
        p.green_in = rand_chan();
        p.blue_in  = rand_chan();
        send_pixel(p);
      end
      wait_drained();
    end

    repeat (LATENCY + 20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bcs_pkg.sv
rtl/bcs_stream_if.sv
rtl/bcs_cfg.sv
rtl/bcs_contrast.sv
rtl/bcs_luma.sv
rtl/bcs_sat.sv
rtl/rgb_brightness_contrast_saturation.sv
rtl/bcs_checker.sv
test/rgb_brightness_contrast_saturation_test.sv
